// ===== design/sps_pkg.sv =====
package sps_pkg;

   localparam int MAX_POINTS = 32;
   localparam int NW = $clog2(MAX_POINTS + 1);   // width of a point count
   localparam int RW = NW + 1;                   // divider remainder width
   localparam int CW = 6;                        // sequencer step counter
   localparam int SQRT_STEPS = 34;
   localparam int DIV_STEPS = 33;
   localparam int MUL_STEPS = 3;

   localparam logic [1:0] CSR_TRAIL_ENABLE = 2'd0;
   localparam logic [1:0] CSR_DENSITY      = 2'd1;
   localparam logic [1:0] CSR_MIN_LENGTH   = 2'd2;
   localparam logic [1:0] CSR_HEAD_SIZE    = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SQRT,
      ST_NCALC,
      ST_DIV,
      ST_PINIT,
      ST_PLOAD,
      ST_PWAIT,
      ST_HLOAD,
      ST_HWAIT
   } state_type;

   typedef struct packed {
      logic          load;
      logic          sq_en;
      logic [1:0]    sq_sel;
      logic          sqrt_step;
      logic          ncalc;
      logic          div_step;
      logic          pt_init;
      logic          pt_adv;
      logic          out_trail;
      logic          out_head;
      logic          out_last;
   } cmd_type;

   typedef struct packed {
      logic          go;
      logic [NW-1:0] n;
      logic          has_head;
   } status_type;

endpackage

// ===== design/sps_if.sv =====
interface sps_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic signed [31:0] prev_x;
   logic signed [31:0] prev_y;
   logic signed [31:0] prev_z;
   logic signed [31:0] cur_x;
   logic signed [31:0] cur_y;
   logic signed [31:0] cur_z;
   logic signed [31:0] time_step;
   modport source (output valid, kind, prev_x, prev_y, prev_z, cur_x, cur_y, cur_z,
                   time_step, input ready);
   modport sink (input valid, kind, prev_x, prev_y, prev_z, cur_x, cur_y, cur_z,
                 time_step, output ready);
endinterface

interface sps_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic        is_head;
   logic        last;
   modport source (output valid, point_x, point_y, point_z, is_head, last, input ready);
   modport sink (input valid, point_x, point_y, point_z, is_head, last, output ready);
endinterface

// ===== design/sps_ctrl.sv =====
module sps_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  sps_pkg::status_type status,
   output sps_pkg::cmd_type    cmd
);
   import sps_pkg::*;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic          idx_last;

   assign idx_last = (idx_ff == status.n - NW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid && status.go) state_in = ST_MUL;
         end
         ST_MUL: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(MUL_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(SQRT_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_NCALC;
            end
         end
         ST_NCALC: state_in = ST_DIV;
         ST_DIV: begin
            // with no trail points the quotients are never used
            if (status.n == '0) begin
               state_in = status.has_head ? ST_HLOAD : ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
               if (cnt_ff == CW'(DIV_STEPS - 1)) begin
                  cnt_in   = '0;
                  state_in = ST_PINIT;
               end
            end
         end
         ST_PINIT: begin
            idx_in   = '0;
            state_in = ST_PLOAD;
         end
         ST_PLOAD: state_in = ST_PWAIT;
         ST_PWAIT: begin
            if (rsp_ready) begin
               if (idx_last) begin
                  state_in = status.has_head ? ST_HLOAD : ST_IDLE;
               end else begin
                  idx_in   = idx_ff + NW'(1);
                  state_in = ST_PLOAD;
               end
            end
         end
         ST_HLOAD: state_in = ST_HWAIT;
         ST_HWAIT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MUL: begin
            cmd.sq_en  = 1'b1;
            cmd.sq_sel = cnt_ff[1:0];
         end
         ST_SQRT:  cmd.sqrt_step = 1'b1;
         ST_NCALC: cmd.ncalc = 1'b1;
         ST_DIV:   cmd.div_step = (status.n != '0);
         ST_PINIT: cmd.pt_init = 1'b1;
         ST_PLOAD: begin
            cmd.out_trail = 1'b1;
            cmd.out_last  = idx_last && !status.has_head;
         end
         ST_PWAIT: begin
            rsp_valid  = 1'b1;
            cmd.pt_adv = rsp_ready && !idx_last;
         end
         ST_HLOAD: begin
            cmd.out_head = 1'b1;
            cmd.out_last = 1'b1;
         end
         ST_HWAIT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

// ===== design/sps_datapath.sv =====
module sps_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   sps_req_if.sink             req,
   output logic signed [31:0]  point_x,
   output logic signed [31:0]  point_y,
   output logic signed [31:0]  point_z,
   output logic                is_head,
   output logic                last,
   input  sps_pkg::cmd_type    cmd,
   output sps_pkg::status_type status
);
   import sps_pkg::*;

   logic        enable_ff;
   logic [15:0] density_ff, min_len_ff, head_sz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         density_ff   <= 16'd2048;
         min_len_ff   <= 16'd655;
         head_sz_ff   <= 16'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TRAIL_ENABLE: enable_ff    <= csr_wdata[0];
            CSR_DENSITY:      density_ff   <= csr_wdata;
            CSR_MIN_LENGTH:   min_len_ff   <= csr_wdata;
            CSR_HEAD_SIZE:    head_sz_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured segment
   logic signed [31:0] prev_ff [3];
   logic signed [31:0] cur_ff [3];
   logic signed [31:0] ts_ff;
   logic               neg_ff [3];
   logic [32:0]        mag_ff [3];    // |delta|, becomes quotient during divide
   logic signed [32:0] delta [3];
   logic signed [31:0] prev_in [3];
   logic signed [31:0] cur_in [3];

   assign prev_in[0] = req.prev_x;
   assign prev_in[1] = req.prev_y;
   assign prev_in[2] = req.prev_z;
   assign cur_in[0]  = req.cur_x;
   assign cur_in[1]  = req.cur_y;
   assign cur_in[2]  = req.cur_z;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         delta[a] = 33'(cur_in[a]) - 33'(prev_in[a]);
      end
   end

   assign status.go       = req.kind && enable_ff;
   assign status.has_head = (head_sz_ff != 16'd0);

   // sum of squares, then restoring square root consuming it two bits a step
   logic [67:0] sum_ff;
   logic [36:0] srem_ff;
   logic [33:0] root_ff;
   logic [32:0] sq_op;
   logic [65:0] sq_prod;
   logic [36:0] srem_sh;
   logic [35:0] strial;

   assign sq_op   = mag_ff[cmd.sq_sel];
   assign sq_prod = 66'(sq_op) * 66'(sq_op);
   assign srem_sh = {srem_ff[34:0], sum_ff[67:66]};
   assign strial  = {root_ff, 2'b01};

   // divider state
   logic [NW-1:0] n_ff;
   logic [RW-1:0] drem_ff [3];
   logic [NW-1:0] den;
   logic [49:0]   nprod;
   logic [26:0]   nraw;

   assign status.n = n_ff;
   assign den      = (n_ff == NW'(1)) ? NW'(2) : n_ff - NW'(1);
   assign nprod    = 50'(root_ff) * 50'(density_ff);
   assign nraw     = 27'((nprod + 50'h0FF_FFFF) >> 24);

   // point accumulators: q = floor(|d|*i/den), r = remainder
   logic [32:0]   q_ff [3];
   logic [RW-1:0] r_ff [3];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int a = 0; a < 3; a++) begin
            prev_ff[a] <= prev_in[a];
            cur_ff[a]  <= cur_in[a];
            neg_ff[a]  <= delta[a][32];
            mag_ff[a]  <= delta[a][32] ? 33'(-delta[a]) : 33'(delta[a]);
            drem_ff[a] <= '0;
         end
         ts_ff   <= req.time_step;
         sum_ff  <= '0;
         srem_ff <= '0;
         root_ff <= '0;
      end
      if (cmd.sq_en) sum_ff <= sum_ff + 68'(sq_prod);
      if (cmd.sqrt_step) begin
         sum_ff <= {sum_ff[65:0], 2'b00};
         if (srem_sh >= 37'(strial)) begin
            srem_ff <= srem_sh - 37'(strial);
            root_ff <= {root_ff[32:0], 1'b1};
         end else begin
            srem_ff <= srem_sh;
            root_ff <= {root_ff[32:0], 1'b0};
         end
      end
      if (cmd.ncalc) begin
         if (ts_ff > 32'sd0 && root_ff >= 34'(min_len_ff)) begin
            n_ff <= (nraw > 27'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(nraw);
         end else begin
            n_ff <= '0;
         end
      end
      if (cmd.div_step) begin
         for (int a = 0; a < 3; a++) begin
            logic [RW-1:0] t;
            t = {drem_ff[a][NW-1:0], mag_ff[a][32]};
            if (t >= RW'(den)) begin
               drem_ff[a] <= t - RW'(den);
               mag_ff[a]  <= {mag_ff[a][31:0], 1'b1};
            end else begin
               drem_ff[a] <= t;
               mag_ff[a]  <= {mag_ff[a][31:0], 1'b0};
            end
         end
      end
      if (cmd.pt_init) begin
         for (int a = 0; a < 3; a++) begin
            // a single point sits at the midpoint: start one step in
            q_ff[a] <= (n_ff == NW'(1)) ? mag_ff[a] : '0;
            r_ff[a] <= (n_ff == NW'(1)) ? drem_ff[a] : '0;
         end
      end
      if (cmd.pt_adv) begin
         for (int a = 0; a < 3; a++) begin
            logic [RW-1:0] r2;
            r2 = r_ff[a] + drem_ff[a];
            if (r2 >= RW'(den)) begin
               r_ff[a] <= r2 - RW'(den);
               q_ff[a] <= q_ff[a] + mag_ff[a] + 33'd1;
            end else begin
               r_ff[a] <= r2;
               q_ff[a] <= q_ff[a] + mag_ff[a];
            end
         end
      end
   end

   logic signed [33:0] pt [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         pt[a] = neg_ff[a] ? 34'(prev_ff[a]) - 34'(q_ff[a])
                           : 34'(prev_ff[a]) + 34'(q_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_trail) begin
         point_x <= pt[0][31:0];
         point_y <= pt[1][31:0];
         point_z <= pt[2][31:0];
         is_head <= 1'b0;
         last    <= cmd.out_last;
      end else if (cmd.out_head) begin
         point_x <= cur_ff[0];
         point_y <= cur_ff[1];
         point_z <= cur_ff[2];
         is_head <= 1'b1;
         last    <= cmd.out_last;
      end
   end

endmodule

// ===== design/segment_point_subdivider_core.sv =====
// Segment point subdivider.
// req_chan carries one segment per beat (kind, prev and cur points in Q16.16,
// time step). rsp_chan returns the trail points, evenly spaced from prev to
// cur, then an optional head point at cur; the final beat of a segment has
// last set. A segment with kind none, or with the block disabled, is taken
// while idle and produces no beats.
// csr_we/csr_index/csr_wdata write trail enable, density, min length and
// head size; write them only while the block is idle.
// Steps per segment: accept, squaring of the three deltas on one shared
// multiplier, 34 square-root steps (two radicand bits per cycle), the point
// count, 33 divide steps (three lanes in parallel, one quotient bit per
// cycle), a setup step, then per beat a load into the output register and a
// wait until it is taken; at most 32 trail points and a head. With no trail
// points the divide and setup are skipped.
// One segment is in flight at a time; req_chan.ready is high only while idle.
// Results sit in an output register; if the receiver stalls, the beat is
// held and the sequencer waits. Synchronous reset returns to idle and loads
// the register defaults (enabled, density 8.0, min length 655, no head).
module segment_point_subdivider_core (
   input  logic        clock,
   input  logic        reset,
   sps_req_if.sink     req_chan,
   sps_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import sps_pkg::*;

   cmd_type    cmd;
   status_type status;

   sps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sps_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_chan),
      .point_x   (rsp_chan.point_x),
      .point_y   (rsp_chan.point_y),
      .point_z   (rsp_chan.point_z),
      .is_head   (rsp_chan.is_head),
      .last      (rsp_chan.last),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
